// ----- sv/swms_pkg.sv -----
// Package for the sliding window maximum sum block: field widths, fixed constants
// and the types shared by the top level, the response queue and the bench.
// Depends on nothing.
package swms_pkg;

   localparam int SAMPLE_W    = 32;   // width of one input sample
   localparam int SUM_W       = 42;   // width of window sums
   localparam int LEN_W       = 11;   // width of the window length register
   localparam int RSP_DEPTH   = 8;    // entries in the response queue
   localparam int RSP_PTR_W   = 3;    // pointer width into the response queue
   localparam int RSP_CNT_W   = 4;    // fill count width, holds RSP_DEPTH itself

   localparam logic [LEN_W-1:0] COUNT_MAX  = 11'd2047;
   localparam logic [LEN_W-1:0] LEN_RESET  = 11'd1;

   // One result word as it waits in the response queue.
   typedef struct packed {
      logic signed [SUM_W-1:0] max_sum;
      logic                    found;
   } rsp_entry_type;

   // Control flags that follow a sample down the pipeline.
   typedef struct packed {
      logic valid;   // stage holds a sample
      logic last;    // sample closes its sequence
      logic sub;     // oldest sample leaves the window
      logic set;     // first full window: best takes the sum
      logic upd;     // later window: best takes the sum if larger
      logic found;   // a full window exists at the end of the sequence
   } stage_ctl_type;

endpackage

// ----- sv/swms_if.sv -----
// Valid/ready channel interfaces for the sample and result words.
// Depends on swms_pkg for the field widths.
interface swms_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [swms_pkg::SAMPLE_W-1:0]  sample;
   logic                                  last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swms_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [swms_pkg::SUM_W-1:0]     max_sum;
   logic                                  found;

   modport source (output valid, output max_sum, output found, input ready);
   modport sink   (input valid, input max_sum, input found, output ready);
endinterface

// ----- sv/swms_rsp_fifo.sv -----
// Small response queue that holds finished result words until the consumer takes them.
// Depends on swms_pkg for the entry type and the queue depth.
module swms_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  swms_pkg::rsp_entry_type             push_data,
   input  logic                                pop,
   output swms_pkg::rsp_entry_type             head_data,
   output logic [swms_pkg::RSP_CNT_W-1:0]      fill_count
);

   swms_pkg::rsp_entry_type                 fifo_mem [swms_pkg::RSP_DEPTH];
   logic [swms_pkg::RSP_PTR_W-1:0]          wr_ptr_ff;
   logic [swms_pkg::RSP_PTR_W-1:0]          rd_ptr_ff;
   logic [swms_pkg::RSP_CNT_W-1:0]          count_ff;
   logic [swms_pkg::RSP_CNT_W-1:0]          count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data  = fifo_mem[rd_ptr_ff];
   assign fill_count = count_ff;

endmodule

// ----- sv/sliding_window_max_sum.sv -----
// Top level of the sliding window maximum sum block: ring memory, sum pipeline
// and result queue. Depends on swms_pkg, swms_if and swms_rsp_fifo.
//
//   Channel   Direction  Handshake          Word
//   req_if    in         valid / ready      sample (signed 32), last
//   rsp_if    out        valid / ready      max_sum (signed 42), found
//   csr_*     in         csr_write_en       window_len (11 bits), no read-back
//
// One sample is taken per cycle while req_if.ready is high. A sample passes the
// ring read, delta, running sum and best sum stages, and its result word, if it
// closes a sequence, can be taken from rsp_if in the cycle after the last stage.
// The running sum and the best sum each close a loop through one register, which sets the rate.
// Reset is synchronous and needs no clearing pass: the ring memory is only read
// at entries written earlier in the same sequence.
// A stalled consumer fills the eight-entry result queue; req_if.ready drops once
// the queue plus the sequence ends still in flight could overrun it.

module sliding_window_max_sum #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   swms_req_if.sink                         req_if,
   swms_rsp_if.source                       rsp_if,
   input  logic                             csr_write_en,
   input  logic [swms_pkg::LEN_W-1:0]       csr_window_len
);

   // Ring addressing. A window of one entry still needs a one-bit address.
   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   // Room for slot + MAX_WINDOW before the wrap correction.
   localparam int OFS_W  = ADDR_W + 2;

   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(MAX_WINDOW - 1);

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [swms_pkg::LEN_W-1:0] window_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= swms_pkg::LEN_RESET;
      end else if (csr_write_en) begin
         window_len_ff <= csr_window_len;
      end
   end

   // ------------------------------------------------------------------
   // Stage 0: accept, ring write, ring read of the leaving sample
   // ------------------------------------------------------------------
   logic                        accept;
   logic [swms_pkg::LEN_W-1:0]  seen_count_ff;
   logic [swms_pkg::LEN_W-1:0]  seen_count_in;
   logic [ADDR_W-1:0]           write_slot_ff;
   logic [ADDR_W-1:0]           write_slot_in;
   logic [swms_pkg::LEN_W-1:0]  new_count;
   logic                        len_ok;
   logic [OFS_W-1:0]            old_ofs;
   logic [ADDR_W-1:0]           rd_addr;
   swms_pkg::stage_ctl_type     ctl0;

   assign accept = req_if.valid && req_if.ready;

   // A window length of zero, or one longer than the ring, never yields a window.
   assign len_ok = (window_len_ff != '0) && (32'(window_len_ff) <= 32'(MAX_WINDOW));

   assign new_count = (seen_count_ff == swms_pkg::COUNT_MAX) ?
                      swms_pkg::COUNT_MAX : seen_count_ff + 1'b1;

   // The leaving sample sits window_len slots behind the write slot. The
   // address only matters when the length is in range, so it fits OFS_W bits.
   always_comb begin
      old_ofs = OFS_W'(write_slot_ff) + OFS_W'(MAX_WINDOW) - OFS_W'(window_len_ff);
      if (old_ofs >= OFS_W'(MAX_WINDOW)) begin
         rd_addr = ADDR_W'(old_ofs - OFS_W'(MAX_WINDOW));
      end else begin
         rd_addr = ADDR_W'(old_ofs);
      end
   end

   always_comb begin
      ctl0.valid = accept;
      ctl0.last  = req_if.last;
      ctl0.sub   = len_ok && (seen_count_ff >= window_len_ff);
      ctl0.set   = len_ok && (new_count == window_len_ff);
      ctl0.upd   = len_ok && (new_count > window_len_ff);
      ctl0.found = len_ok && (new_count >= window_len_ff);
   end

   always_comb begin
      seen_count_in = seen_count_ff;
      write_slot_in = write_slot_ff;
      if (accept) begin
         if (req_if.last) begin
            seen_count_in = '0;
            write_slot_in = '0;
         end else begin
            seen_count_in = new_count;
            write_slot_in = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= '0;
         write_slot_ff <= '0;
      end else begin
         seen_count_ff <= seen_count_in;
         write_slot_ff <= write_slot_in;
      end
   end

   // Ring memory, read-first. When the window spans the whole ring the read and
   // the write hit the same entry, and the read must see the older sample,
   // which read-first gives. Later reads always see earlier writes.
   logic [swms_pkg::SAMPLE_W-1:0] window_store [MAX_WINDOW];
   logic [swms_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= window_store[rd_addr];
      if (accept) begin
         window_store[write_slot_ff] <= req_if.sample;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: delta = incoming sample, minus (once the window is full) the leaving sample
   // ------------------------------------------------------------------
   swms_pkg::stage_ctl_type        ctl1_ff;
   logic [swms_pkg::SAMPLE_W-1:0]  sample1_ff;
   logic [swms_pkg::SAMPLE_W:0]    delta_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= ctl0;
      end
   end

   always_ff @(posedge clock) begin
      sample1_ff <= req_if.sample;
   end

   always_comb begin
      delta_in = {sample1_ff[swms_pkg::SAMPLE_W-1], sample1_ff};
      if (ctl1_ff.sub) begin
         delta_in = delta_in - {rd_data_ff[swms_pkg::SAMPLE_W-1], rd_data_ff};
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: running sum
   // ------------------------------------------------------------------
   swms_pkg::stage_ctl_type        ctl2_ff;
   logic [swms_pkg::SAMPLE_W:0]    delta2_ff;
   logic [swms_pkg::SUM_W-1:0]     running_sum_ff;
   logic [swms_pkg::SUM_W-1:0]     sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      delta2_ff <= delta_in;
   end

   assign sum_in = running_sum_ff +
      {{(swms_pkg::SUM_W-swms_pkg::SAMPLE_W-1){delta2_ff[swms_pkg::SAMPLE_W]}}, delta2_ff};

   // The sum restarts from zero after the word that closes a sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
      end else if (ctl2_ff.valid) begin
         running_sum_ff <= ctl2_ff.last ? '0 : sum_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: best sum and result
   // ------------------------------------------------------------------
   swms_pkg::stage_ctl_type          ctl3_ff;
   logic signed [swms_pkg::SUM_W-1:0] sum3_ff;
   logic signed [swms_pkg::SUM_W-1:0] best_sum_ff;
   logic signed [swms_pkg::SUM_W-1:0] best_in;
   swms_pkg::rsp_entry_type           rsp_push_data;
   logic                              rsp_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum3_ff <= sum_in;
   end

   always_comb begin
      best_in = best_sum_ff;
      if (ctl3_ff.set || (ctl3_ff.upd && (sum3_ff > best_sum_ff))) begin
         best_in = sum3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_sum_ff <= '0;
      end else if (ctl3_ff.valid) begin
         best_sum_ff <= ctl3_ff.last ? '0 : best_in;
      end
   end

   assign rsp_push               = ctl3_ff.valid && ctl3_ff.last;
   assign rsp_push_data.max_sum  = ctl3_ff.found ? best_in : '0;
   assign rsp_push_data.found    = ctl3_ff.found;

   // ------------------------------------------------------------------
   // Result queue and input back-pressure
   // ------------------------------------------------------------------
   swms_pkg::rsp_entry_type           rsp_head;
   logic [swms_pkg::RSP_CNT_W-1:0]    rsp_fill;
   logic                              rsp_pop;
   logic [swms_pkg::RSP_CNT_W:0]      reserved;

   assign rsp_pop = rsp_if.valid && rsp_if.ready;

   swms_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .push_data  (rsp_push_data),
      .pop        (rsp_pop),
      .head_data  (rsp_head),
      .fill_count (rsp_fill)
   );

   // Every sequence end in flight holds a place in the queue, so a push never
   // finds it full. The incoming word may be an end as well.
   assign reserved = (swms_pkg::RSP_CNT_W+1)'(rsp_fill)
                   + (swms_pkg::RSP_CNT_W+1)'(ctl1_ff.valid && ctl1_ff.last)
                   + (swms_pkg::RSP_CNT_W+1)'(ctl2_ff.valid && ctl2_ff.last)
                   + (swms_pkg::RSP_CNT_W+1)'(ctl3_ff.valid && ctl3_ff.last);

   assign req_if.ready   = reserved < (swms_pkg::RSP_CNT_W+1)'(swms_pkg::RSP_DEPTH);

   assign rsp_if.valid   = rsp_fill != '0;
   assign rsp_if.max_sum = rsp_head.max_sum;
   assign rsp_if.found   = rsp_head.found;

endmodule

// ----- sv/swms_checker.sv -----
// Port-level checker for the sliding window maximum sum block, and its bind.
// Depends on swms_pkg and on the top level's port names.
module swms_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [swms_pkg::SUM_W-1:0] rsp_max_sum,
   input logic                             rsp_found
);

   // A result word waiting for the consumer stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn while stalled");

   // A stalled result word keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_max_sum) && $stable(rsp_found))
      else $error("result word changed while stalled");

   // A sequence without a full window reports a zero sum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_max_sum == '0)
      else $error("non-zero sum without a full window");

   // After reset the pipeline and queue are empty: no result, input open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind sliding_window_max_sum swms_checker u_swms_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_max_sum (rsp_if.max_sum),
   .rsp_found   (rsp_if.found)
);

// ----- bench/tb_sliding_window_max_sum.sv -----
// Self-checking bench for sliding_window_max_sum: streams signed sample words
// through the block and checks each maximum window sum against its own model.
// Depends on swms_pkg, swms_if and the block's RTL.
module tb_sliding_window_max_sum;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int RING_DEPTH     = 1024;  // MAX_WINDOW of the block under test
   localparam int SETTLE_CYCLES  = 8;     // four pipeline stages plus the queue, with margin
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int NUM_PHASES     = 16;
   localparam int PHASE_BUDGET   = 50;    // random words queued per phase, at least
   localparam int SEQ_LEN_CAP    = 64;    // longest window that gets long random sequences

   localparam logic [swms_pkg::SAMPLE_W-1:0] SAMPLE_TOP    = 32'h7FFF_FFFF;
   localparam logic [swms_pkg::SAMPLE_W-1:0] SAMPLE_BOTTOM = 32'h8000_0000;

   // How the sample values of one sequence are chosen.
   typedef enum int {
      FLAV_FULL,      // uniform over the whole 32-bit range
      FLAV_SMALL,     // small values around zero, so sums stay readable
      FLAV_TOP,       // every sample at the positive extreme
      FLAV_BOTTOM,    // every sample at the negative extreme
      FLAV_EXTREME    // a mix of the extremes, zero, minus one and noise
   } flavour_type;

   // Handshake pressure applied during a phase.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One sample word waiting to be offered; hold makes the sender wait until
   // every outstanding maximum has been collected before offering it.
   typedef struct {
      logic [swms_pkg::SAMPLE_W-1:0] sample;
      logic                          last;
      bit                            hold;
   } sample_word_type;

   // Clock, reset and every block input start at known values.
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          drv_valid  = 1'b0;
   logic [swms_pkg::SAMPLE_W-1:0] drv_sample = '0;
   logic                          drv_last   = 1'b0;
   logic                          rsp_ready  = 1'b0;
   logic                          csr_we     = 1'b0;
   logic [swms_pkg::LEN_W-1:0]    csr_len    = '0;

   swms_req_if req_bus ();
   swms_rsp_if rsp_bus ();

   assign req_bus.valid  = drv_valid;
   assign req_bus.sample = drv_sample;
   assign req_bus.last   = drv_last;
   assign rsp_bus.ready  = rsp_ready;

   sliding_window_max_sum #(
      .MAX_WINDOW (RING_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_we),
      .csr_window_len (csr_len)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Stimulus waiting to be offered and the maxima still owed by the block.
   sample_word_type           sample_queue [$];
   swms_pkg::rsp_entry_type   maxima_due   [$];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  mismatches     = 0;
   int  stall_cycles   = 0;
   // Set at the rising edge at which the word on offer was taken.
   logic req_taken     = 1'b0;

   // ----------------------------------------------------------------------
   // Window model. It mirrors the block's sequence state: the ring of recent
   // samples, the running window sum, the best full-window sum, the number of
   // samples seen (saturating) and the ring write position.
   // ----------------------------------------------------------------------
   logic [swms_pkg::SAMPLE_W-1:0] ring_words [RING_DEPTH];
   logic [swms_pkg::SUM_W-1:0]    window_total;
   logic [swms_pkg::SUM_W-1:0]    best_total;
   logic [swms_pkg::LEN_W-1:0]    seen_samples;
   logic [9:0]                    ring_slot;
   logic [swms_pkg::LEN_W-1:0]    window_len_cfg;

   function automatic void clear_sequence_state();
      window_total = '0;
      best_total   = '0;
      seen_samples = '0;
      ring_slot    = '0;
   endfunction

   // Folds one accepted sample into the model. When the sample closes its
   // sequence, closes is set and word holds the maximum the block must emit.
   function automatic void fold_sample(input logic [swms_pkg::SAMPLE_W-1:0] sample,
                                       input logic last,
                                       output bit closes,
                                       output swms_pkg::rsp_entry_type word);
      logic [swms_pkg::SUM_W-1:0]    sum;
      logic [swms_pkg::SAMPLE_W-1:0] leaving;
      logic [swms_pkg::LEN_W-1:0]    new_count;
      int                            old_slot;
      bit                            len_ok;

      len_ok = (window_len_cfg >= 1) && (window_len_cfg <= RING_DEPTH);
      sum    = window_total
             + {{(swms_pkg::SUM_W - swms_pkg::SAMPLE_W){sample[swms_pkg::SAMPLE_W-1]}},
                sample};

      // Once the window is full the oldest sample drops out in the same step.
      if (len_ok && seen_samples >= window_len_cfg) begin
         old_slot = (int'(ring_slot) + RING_DEPTH - int'(window_len_cfg)) % RING_DEPTH;
         leaving  = ring_words[old_slot];
         sum      = sum
                  - {{(swms_pkg::SUM_W - swms_pkg::SAMPLE_W){leaving[swms_pkg::SAMPLE_W-1]}},
                     leaving};
      end

      ring_words[ring_slot] = sample;
      ring_slot             = ring_slot + 1'b1;
      new_count             = (seen_samples < swms_pkg::COUNT_MAX) ?
                              seen_samples + 1'b1 : swms_pkg::COUNT_MAX;
      window_total          = sum;

      // The first full window always sets the best sum, even when negative.
      if (len_ok) begin
         if (new_count == window_len_cfg)
            best_total = sum;
         else if (new_count > window_len_cfg && $signed(sum) > $signed(best_total))
            best_total = sum;
      end
      seen_samples = new_count;

      closes = last;
      word   = '0;
      if (last) begin
         word.found   = len_ok && (seen_samples >= window_len_cfg);
         word.max_sum = word.found ? best_total : '0;
         clear_sequence_state();
      end
   endfunction

   // ----------------------------------------------------------------------
   // Sample driver: offers the next queued word at the falling edge once the
   // previous one has been taken, idling at random. A word marked hold is not
   // offered while any maximum is still owed.
   // ----------------------------------------------------------------------
   always @(negedge clock) begin : req_driver
      sample_word_type nxt;
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_taken) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct
             && !(sample_queue[0].hold && maxima_due.size() != 0)) begin
            nxt = sample_queue.pop_front();
            drv_valid  <= 1'b1;
            drv_sample <= nxt.sample;
            drv_last   <= nxt.last;
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Result receiver: ready changes only at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // ----------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Register writes and
   // accepted samples go into the model, and each accepted result word is
   // compared with the oldest maximum owed.
   // ----------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      bit                      closes;
      swms_pkg::rsp_entry_type word;
      swms_pkg::rsp_entry_type due;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= drv_valid && req_bus.ready;
         if (csr_we)
            window_len_cfg = csr_len;
         if (drv_valid && req_bus.ready) begin
            fold_sample(drv_sample, drv_last, closes, word);
            if (closes)
               maxima_due.push_back(word);
         end
         if (rsp_bus.valid && rsp_ready) begin
            if (maxima_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result word max_sum=%0d found=%0b",
                           $realtime, $signed(rsp_bus.max_sum), rsp_bus.found);
            end else begin
               due = maxima_due.pop_front();
               if (rsp_bus.max_sum !== due.max_sum || rsp_bus.found !== due.found) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: result word differs: max_sum exp %0d got %0d,",
                               " found exp %0b got %0b"},
                              $realtime, $signed(due.max_sum), $signed(rsp_bus.max_sum),
                              due.found, rsp_bus.found);
               end
            end
         end
      end
   end

   // Watchdog: counts cycles without any handshake while work is outstanding.
   always @(posedge clock) begin
      if (reset || (drv_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (sample_queue.size() != 0 || maxima_due.size() != 0 || drv_valid) begin
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // ----------------------------------------------------------------------
   // Stimulus helpers.
   // ----------------------------------------------------------------------
   function automatic logic [swms_pkg::SAMPLE_W-1:0] pick_sample(input flavour_type flavour);
      int offset;
      case (flavour)
         FLAV_SMALL: begin
            offset = $urandom_range(200);
            return 32'(offset - 100);
         end
         FLAV_TOP:    return SAMPLE_TOP;
         FLAV_BOTTOM: return SAMPLE_BOTTOM;
         FLAV_EXTREME: begin
            case ($urandom_range(4))
               0:       return SAMPLE_TOP;
               1:       return SAMPLE_BOTTOM;
               2:       return '0;
               3:       return '1;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_sequence(input int n, input flavour_type flavour, input bit hold);
      sample_word_type w;
      for (int i = 0; i < n; i++) begin
         w.sample = pick_sample(flavour);
         w.last   = (i == n - 1);
         w.hold   = hold && (i == 0);
         sample_queue.push_back(w);
      end
   endtask

   // Queues a directed sequence whose samples are given explicitly.
   task automatic queue_words(input logic [swms_pkg::SAMPLE_W-1:0] words [$]);
      sample_word_type w;
      foreach (words[i]) begin
         w.sample = words[i];
         w.last   = (i == words.size() - 1);
         w.hold   = 1'b0;
         sample_queue.push_back(w);
      end
   endtask

   // Waits until the block has nothing left to do: every word offered and
   // taken, every maximum collected, and the pipeline given time to empty.
   task automatic settle();
      while (sample_queue.size() != 0 || maxima_due.size() != 0 || drv_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only once the block has settled.
   task automatic set_window(input logic [swms_pkg::LEN_W-1:0] len);
      settle();
      @(negedge clock);
      csr_we  <= 1'b1;
      csr_len <= len;
      @(negedge clock);
      csr_we  <= 1'b0;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin send_idle_pct = 73; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         IDLE_BOTH:     begin send_idle_pct = 7;  recv_stall_pct = 7;  end
         default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // Window length used by each random phase. The list includes zero, one,
   // the ring depth, one beyond it and the largest value the register holds.
   function automatic logic [swms_pkg::LEN_W-1:0] phase_len(input int p);
      case (p)
         0:       return 11'd1;
         1:       return 11'd2;
         2:       return 11'd0;
         3:       return 11'd5;
         4:       return 11'd1024;
         5:       return 11'd16;
         6:       return 11'd3;
         7:       return 11'd2047;
         8:       return 11'd7;
         9:       return 11'd1025;
         10:      return 11'd1;
         11:      return 11'd33;
         12:      return 11'd4;
         13:      return 11'd64;
         14:      return 11'd2;
         default: return 11'd9;
      endcase
   endfunction

   // ----------------------------------------------------------------------
   // Test sequence.
   // ----------------------------------------------------------------------
   initial begin
      int                         queued;
      int                         n;
      bit                         hold;
      logic [swms_pkg::LEN_W-1:0] len;

      // The model starts from the block's reset state: empty sequence and a
      // window of one sample. The ring holds nothing readable yet.
      foreach (ring_words[i])
         ring_words[i] = '0;
      clear_sequence_state();
      window_len_cfg = swms_pkg::LEN_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, first at the reset window length of one.
      set_idle(IDLE_NONE);
      queue_words('{SAMPLE_TOP});
      queue_words('{SAMPLE_BOTTOM, 32'hFFFF_FFFF, 32'h0});

      // Window of three: a negative first window must still set the best,
      // a sequence one short yields no window, an exact fit yields one.
      set_window(11'd3);
      queue_words('{SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_BOTTOM, SAMPLE_TOP});
      queue_words('{32'd5, 32'd6});
      queue_words('{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD});

      // A zero window never yields a window: its result words report none found.
      set_window(11'd0);
      queue_words('{32'd1, 32'd2});

      // Windows larger than the ring are counted but never reported as found.
      set_window(11'd1025);
      queue_words('{SAMPLE_TOP, SAMPLE_TOP});
      set_window(11'd2047);
      queue_words('{32'd7});

      // Random phases, each with its own window length and handshake pressure.
      for (int p = 0; p < NUM_PHASES; p++) begin
         len = phase_len(p);
         set_window(len);
         set_idle(idle_mode_type'(p % 4));

         queued = 0;
         while (queued < PHASE_BUDGET) begin
            // Very long windows only see short sequences, which end without
            // a full window.
            if (len == 0 || len > SEQ_LEN_CAP)
               n = $urandom_range(8, 1);
            else
               n = $urandom_range(2 * len + 4, 1);
            // Now and then, and always once early on, the sender holds back
            // until every outstanding maximum has been collected.
            hold = ($urandom_range(9) == 0) || (p == 1 && queued == 0);
            queue_sequence(n, flavour_type'($urandom_range(FLAV_EXTREME)), hold);
            queued += n;
         end
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- files.f -----
sv/swms_pkg.sv
sv/swms_if.sv
sv/swms_rsp_fifo.sv
sv/sliding_window_max_sum.sv
sv/swms_checker.sv
bench/tb_sliding_window_max_sum.sv
